// File: rtl/qtr_pkg.sv
package qtr_pkg;

	// Signed Q16.16 word.
	localparam int FX_W    = 32;
	localparam int FX_FRAC = 16;
	localparam int PROD_W  = 2 * FX_W;

	typedef logic signed [FX_W-1:0]   fx_t;
	typedef logic signed [PROD_W-1:0] fx_wide_t;

	// The value that any step gives when its exact result does not fit.
	localparam fx_t      FX_MARKER = {1'b1, {(FX_W-1){1'b0}}};
	// One half LSB of the result, added before the product is shifted down.
	localparam fx_wide_t FX_HALF   = fx_wide_t'(1) <<< (FX_FRAC - 1);

	// A value together with the overflow mark of the step that made it.
	typedef struct packed {
		logic ovf;
		fx_t  val;
	} fx_res_t;

	// The ten pairwise products after rounding.
	typedef struct packed {
		fx_t aa;
		fx_t ab;
		fx_t ac;
		fx_t ad;
		fx_t bb;
		fx_t bc;
		fx_t bd;
		fx_t cc;
		fx_t cd;
		fx_t dd;
	} prod_set_t;

	// The nine matrix entries and the sticky overflow flag.
	typedef struct packed {
		fx_t  m00;
		fx_t  m01;
		fx_t  m02;
		fx_t  m10;
		fx_t  m11;
		fx_t  m12;
		fx_t  m20;
		fx_t  m21;
		fx_t  m22;
		logic overflow;
	} mat_t;

	// Full signed product of two Q16.16 words.
	function automatic fx_wide_t fx_mul_full(input fx_t x, input fx_t y);
		fx_wide_t xe;
		fx_wide_t ye;
		xe = x;
		ye = y;
		return xe * ye;
	endfunction

	// Round half up, shift down by the fraction width, and check the range.
	function automatic fx_res_t fx_round(input fx_wide_t p);
		fx_wide_t r;
		fx_res_t  res;
		r = p + FX_HALF;
		res.ovf = (r[PROD_W-1:FX_W+FX_FRAC-1] != '0) && (r[PROD_W-1:FX_W+FX_FRAC-1] != '1);
		res.val = res.ovf ? FX_MARKER : r[FX_W+FX_FRAC-1:FX_FRAC];
		return res;
	endfunction

	function automatic fx_res_t fx_add(input fx_t x, input fx_t y);
		logic signed [FX_W:0] s;
		fx_res_t res;
		s = {x[FX_W-1], x} + {y[FX_W-1], y};
		res.ovf = s[FX_W] != s[FX_W-1];
		res.val = res.ovf ? FX_MARKER : s[FX_W-1:0];
		return res;
	endfunction

	function automatic fx_res_t fx_sub(input fx_t x, input fx_t y);
		logic signed [FX_W:0] s;
		fx_res_t res;
		s = {x[FX_W-1], x} - {y[FX_W-1], y};
		res.ovf = s[FX_W] != s[FX_W-1];
		res.val = res.ovf ? FX_MARKER : s[FX_W-1:0];
		return res;
	endfunction

	// Multiply by the constant 2.0 with rounding: the half LSB never reaches
	// the kept bits, so this is an exact doubling with a range check.
	function automatic fx_res_t fx_dbl(input fx_t x);
		fx_res_t res;
		res.ovf = x[FX_W-1] != x[FX_W-2];
		res.val = res.ovf ? FX_MARKER : {x[FX_W-2:0], 1'b0};
		return res;
	endfunction

endpackage

// File: rtl/qtr_quat_if.sv
interface qtr_quat_if import qtr_pkg::*; ();
	logic valid;
	logic ready;
	fx_t  q_scalar;
	fx_t  q_i;
	fx_t  q_j;
	fx_t  q_k;

	modport source (output valid, output q_scalar, output q_i, output q_j, output q_k,
		input ready);
	modport sink (input valid, input q_scalar, input q_i, input q_j, input q_k,
		output ready);
endinterface

// File: rtl/qtr_mat_if.sv
interface qtr_mat_if import qtr_pkg::*; ();
	logic valid;
	logic ready;
	fx_t  m00;
	fx_t  m01;
	fx_t  m02;
	fx_t  m10;
	fx_t  m11;
	fx_t  m12;
	fx_t  m20;
	fx_t  m21;
	fx_t  m22;
	logic overflow;

	modport source (output valid, output m00, output m01, output m02, output m10,
		output m11, output m12, output m20, output m21, output m22, output overflow,
		input ready);
	modport sink (input valid, input m00, input m01, input m02, input m10,
		input m11, input m12, input m20, input m21, input m22, input overflow,
		output ready);
endinterface

// File: rtl/qtr_mul.sv
module qtr_mul import qtr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  fx_t       a,
	input  fx_t       b,
	input  fx_t       c,
	input  fx_t       d,
	output logic      out_valid,
	input  logic      out_ready,
	output prod_set_t prod,
	output logic      ovf
);

	typedef struct packed {
		fx_wide_t aa;
		fx_wide_t ab;
		fx_wide_t ac;
		fx_wide_t ad;
		fx_wide_t bb;
		fx_wide_t bc;
		fx_wide_t bd;
		fx_wide_t cc;
		fx_wide_t cd;
		fx_wide_t dd;
	} wide_set_t;

	logic      vld_s1;
	logic      vld_s2;
	logic      en_s1;
	logic      en_s2;
	wide_set_t raw_s1;
	prod_set_t prod_s2;
	logic      ovf_s2;
	fx_res_t   r_aa, r_ab, r_ac, r_ad, r_bb, r_bc, r_bd, r_cc, r_cd, r_dd;

	// A stage loads when it is empty or its content moves on this cycle.
	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Stage 1: the ten full-width products.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			raw_s1.aa <= fx_mul_full(a, a);
			raw_s1.ab <= fx_mul_full(a, b);
			raw_s1.ac <= fx_mul_full(a, c);
			raw_s1.ad <= fx_mul_full(a, d);
			raw_s1.bb <= fx_mul_full(b, b);
			raw_s1.bc <= fx_mul_full(b, c);
			raw_s1.bd <= fx_mul_full(b, d);
			raw_s1.cc <= fx_mul_full(c, c);
			raw_s1.cd <= fx_mul_full(c, d);
			raw_s1.dd <= fx_mul_full(d, d);
		end
	end

	// Stage 2: round each product back to Q16.16.
	always_comb begin
		r_aa = fx_round(raw_s1.aa);
		r_ab = fx_round(raw_s1.ab);
		r_ac = fx_round(raw_s1.ac);
		r_ad = fx_round(raw_s1.ad);
		r_bb = fx_round(raw_s1.bb);
		r_bc = fx_round(raw_s1.bc);
		r_bd = fx_round(raw_s1.bd);
		r_cc = fx_round(raw_s1.cc);
		r_cd = fx_round(raw_s1.cd);
		r_dd = fx_round(raw_s1.dd);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			prod_s2.aa <= r_aa.val;
			prod_s2.ab <= r_ab.val;
			prod_s2.ac <= r_ac.val;
			prod_s2.ad <= r_ad.val;
			prod_s2.bb <= r_bb.val;
			prod_s2.bc <= r_bc.val;
			prod_s2.bd <= r_bd.val;
			prod_s2.cc <= r_cc.val;
			prod_s2.cd <= r_cd.val;
			prod_s2.dd <= r_dd.val;
			ovf_s2     <= r_aa.ovf | r_ab.ovf | r_ac.ovf | r_ad.ovf | r_bb.ovf
				| r_bc.ovf | r_bd.ovf | r_cc.ovf | r_cd.ovf | r_dd.ovf;
		end
	end

	assign out_valid = vld_s2;
	assign prod      = prod_s2;
	assign ovf       = ovf_s2;

endmodule

// File: rtl/qtr_sum.sv
module qtr_sum import qtr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  prod_set_t prod,
	input  logic      ovf,
	output logic      out_valid,
	input  logic      out_ready,
	output mat_t      mat
);

	// First level of sums and differences, with the two squares still needed.
	typedef struct packed {
		fx_t  pp;
		fx_t  pm;
		fx_t  x01;
		fx_t  x02;
		fx_t  x10;
		fx_t  x12;
		fx_t  x20;
		fx_t  x21;
		fx_t  cc;
		fx_t  dd;
		logic ovf;
	} lvl1_t;

	// Diagonal partial sums, finished off-diagonal entries and dd.
	typedef struct packed {
		fx_t  d00;
		fx_t  d11;
		fx_t  d22;
		fx_t  m01;
		fx_t  m02;
		fx_t  m10;
		fx_t  m12;
		fx_t  m20;
		fx_t  m21;
		fx_t  dd;
		logic ovf;
	} lvl2_t;

	logic    vld_s3, vld_s4, vld_s5;
	logic    en_s3, en_s4, en_s5;
	lvl1_t   l1_s3;
	lvl2_t   l2_s4;
	mat_t    mat_s5;
	fx_res_t t_pp, t_pm, t_01, t_02, t_10, t_12, t_20, t_21;
	fx_res_t u_00, u_11, u_22, u_01, u_02, u_10, u_12, u_20, u_21;
	fx_res_t w_00, w_11, w_22;

	// Bubble-collapsing valid chain across the three stages.
	assign en_s5    = !vld_s5 || out_ready;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s3) begin
				vld_s3 <= in_valid;
			end
			if (en_s4) begin
				vld_s4 <= vld_s3;
			end
			if (en_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// Stage 3: aa plus/minus bb and the six cross-product pairs.
	always_comb begin
		t_pp = fx_add(prod.aa, prod.bb);
		t_pm = fx_sub(prod.aa, prod.bb);
		t_01 = fx_sub(prod.bc, prod.ad);
		t_02 = fx_add(prod.ac, prod.bd);
		t_10 = fx_add(prod.bc, prod.ad);
		t_12 = fx_sub(prod.cd, prod.ab);
		t_20 = fx_sub(prod.bd, prod.ac);
		t_21 = fx_add(prod.ab, prod.cd);
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			l1_s3.pp  <= t_pp.val;
			l1_s3.pm  <= t_pm.val;
			l1_s3.x01 <= t_01.val;
			l1_s3.x02 <= t_02.val;
			l1_s3.x10 <= t_10.val;
			l1_s3.x12 <= t_12.val;
			l1_s3.x20 <= t_20.val;
			l1_s3.x21 <= t_21.val;
			l1_s3.cc  <= prod.cc;
			l1_s3.dd  <= prod.dd;
			l1_s3.ovf <= ovf | t_pp.ovf | t_pm.ovf | t_01.ovf | t_02.ovf | t_10.ovf
				| t_12.ovf | t_20.ovf | t_21.ovf;
		end
	end

	// Stage 4: fold in cc on the diagonal and double the off-diagonal pairs.
	always_comb begin
		u_00 = fx_sub(l1_s3.pp, l1_s3.cc);
		u_11 = fx_add(l1_s3.pm, l1_s3.cc);
		u_22 = fx_sub(l1_s3.pm, l1_s3.cc);
		u_01 = fx_dbl(l1_s3.x01);
		u_02 = fx_dbl(l1_s3.x02);
		u_10 = fx_dbl(l1_s3.x10);
		u_12 = fx_dbl(l1_s3.x12);
		u_20 = fx_dbl(l1_s3.x20);
		u_21 = fx_dbl(l1_s3.x21);
	end

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			l2_s4.d00 <= u_00.val;
			l2_s4.d11 <= u_11.val;
			l2_s4.d22 <= u_22.val;
			l2_s4.m01 <= u_01.val;
			l2_s4.m02 <= u_02.val;
			l2_s4.m10 <= u_10.val;
			l2_s4.m12 <= u_12.val;
			l2_s4.m20 <= u_20.val;
			l2_s4.m21 <= u_21.val;
			l2_s4.dd  <= l1_s3.dd;
			l2_s4.ovf <= l1_s3.ovf | u_00.ovf | u_11.ovf | u_22.ovf | u_01.ovf
				| u_02.ovf | u_10.ovf | u_12.ovf | u_20.ovf | u_21.ovf;
		end
	end

	// Stage 5: fold in dd on the diagonal; this is the output register.
	always_comb begin
		w_00 = fx_sub(l2_s4.d00, l2_s4.dd);
		w_11 = fx_sub(l2_s4.d11, l2_s4.dd);
		w_22 = fx_add(l2_s4.d22, l2_s4.dd);
	end

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			mat_s5.m00      <= w_00.val;
			mat_s5.m11      <= w_11.val;
			mat_s5.m22      <= w_22.val;
			mat_s5.m01      <= l2_s4.m01;
			mat_s5.m02      <= l2_s4.m02;
			mat_s5.m10      <= l2_s4.m10;
			mat_s5.m12      <= l2_s4.m12;
			mat_s5.m20      <= l2_s4.m20;
			mat_s5.m21      <= l2_s4.m21;
			mat_s5.overflow <= l2_s4.ovf | w_00.ovf | w_11.ovf | w_22.ovf;
		end
	end

	assign out_valid = vld_s5;
	assign mat       = mat_s5;

endmodule

// File: rtl/quaternion_to_rotation_matrix_q16_core.sv
// Quaternion to rotation matrix, signed Q16.16. Each beat on quat carries one
// quaternion (scalar first); each beat on mat carries the nine entries of the
// matching 3x3 direction cosine matrix and an overflow flag, in the same order.
// The block takes one quaternion every cycle unless back-pressure on mat
// stalls it. A beat passes ten parallel 32x32 multipliers, a rounding stage
// and three add/subtract stages in order, each behind its own register. Every
// multiply rounds half up to Q16.16; any multiply, add, subtract or doubling
// that leaves the signed 32-bit range yields 0x80000000 in its place and sets
// overflow for that beat. Back-pressure on mat fills empty stages first, so
// quat.ready drops only when all five stages hold a beat that cannot move.
module quaternion_to_rotation_matrix_q16_core import qtr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	qtr_quat_if.sink   quat,
	qtr_mat_if.source  mat
);

	logic      mid_valid;
	logic      mid_ready;
	prod_set_t mid_prod;
	logic      mid_ovf;
	mat_t      res;

	// Products and rounding.
	qtr_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (quat.valid),
		.in_ready  (quat.ready),
		.a         (quat.q_scalar),
		.b         (quat.q_i),
		.c         (quat.q_j),
		.d         (quat.q_k),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.prod      (mid_prod),
		.ovf       (mid_ovf)
	);

	// Sums, differences and doubling.
	qtr_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.prod      (mid_prod),
		.ovf       (mid_ovf),
		.out_valid (mat.valid),
		.out_ready (mat.ready),
		.mat       (res)
	);

	assign mat.m00      = res.m00;
	assign mat.m01      = res.m01;
	assign mat.m02      = res.m02;
	assign mat.m10      = res.m10;
	assign mat.m11      = res.m11;
	assign mat.m12      = res.m12;
	assign mat.m20      = res.m20;
	assign mat.m21      = res.m21;
	assign mat.m22      = res.m22;
	assign mat.overflow = res.overflow;

`ifndef SYNTH
	// Off-diagonal entries are doubled values or the marker, so always even.
	a_offdiag_even: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid |-> !(mat.m01[0] | mat.m02[0] | mat.m10[0] | mat.m12[0]
			| mat.m20[0] | mat.m21[0]))
		else $error("off-diagonal entry is odd");

	// Without overflow the diagonal entries differ pairwise by even amounts.
	a_diag_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(mat.valid && !mat.overflow) |-> (mat.m00[0] == mat.m11[0])
			&& (mat.m11[0] == mat.m22[0]))
		else $error("diagonal parity mismatch without overflow");

	// The input stalls only when the output holds a beat that is not taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!quat.ready |-> (mat.valid && !mat.ready))
		else $error("input stalled while the output is free");
`endif

endmodule
